/* hdl/sfcd_pkg.sv */
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder package
// Shared types, constants and arithmetic helpers for the frame decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [2:0] FrameLast = 3'd5;

  localparam int unsigned CfgIndexWidth = 4;
  localparam logic [CfgIndexWidth-1:0] CfgTempLow = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] CfgTempHigh = CfgIndexWidth'(1);

  localparam logic signed [11:0] TempLowReset = -12'sd400;
  localparam logic signed [11:0] TempHighReset = 12'sd800;
  localparam logic signed [12:0] TenthsOffset = 13'sd400;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [15:0]       temp_reading;
    logic [7:0]        temperature_check;
    logic [15:0]       hum_reading;
    logic [7:0]        humidity_check;
    logic              temperature_crc_ok;
    logic              humidity_crc_ok;
    logic signed [11:0] temperature_tenths;
    status_e           status;
  } out_t;

  // Complete frame as assembled by the front end.
  typedef struct packed {
    logic [15:0] temp_word;
    logic [7:0]  temp_check;
    logic [15:0] hum_word;
    logic [7:0]  hum_check;
    logic        temp_ok;
    logic        hum_ok;
  } frame_t;

  typedef struct packed {
    logic signed [11:0] low;
    logic signed [11:0] high;
  } limits_t;

  // One byte through CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // 400 + raw * 10 / 256, raw taken as signed, rounded half away from zero.
  function automatic logic signed [11:0] to_tenths(logic [15:0] raw);
    logic signed [19:0] x;
    logic signed [19:0] scaled;
    logic [18:0]        mag;
    logic [18:0]        rounded;
    logic [10:0]        q;
    logic signed [12:0] delta;
    logic signed [12:0] t;
    x = $signed({{4{raw[15]}}, raw});
    scaled = (x <<< 3) + (x <<< 1);
    mag = scaled[19] ? 19'(-scaled) : scaled[18:0];
    rounded = mag + 19'd128;
    q = rounded[18:8];
    delta = scaled[19] ? -$signed({2'b00, q}) : $signed({2'b00, q});
    t = TenthsOffset + delta;
    return t[11:0];
  endfunction

endpackage

/* hdl/sensor_frame_crc_decoder_core.sv */
// A frame is written to the frame queue at the edge that accepts frame byte 5 and moved to the
// output queue when it has room; empty low shows a result. Bytes go in at one per cycle while
// full is low; full rises only when the frame queue between the front and back ends is full.
// Reset: asynchronous, active low; queues empty, byte count zero, CRC 0xFF, limits -400/800.
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder
// Checks two CRC-8 protected words of a six-byte frame and converts the temperature.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_core #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  sfcd_pkg::in_t                        in_data_i,
  output logic                                 empty,
  input  logic                                 pop,
  output sfcd_pkg::out_t                       out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sfcd_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [11:0]                          cfg_data_i
);
  import sfcd_pkg::*;

  logic    in_accept;
  logic    mid_push, mid_full, mid_empty, mid_pop;
  frame_t  mid_in, mid_out;
  logic    res_push, res_full;
  out_t    res_data;
  limits_t limits_q, limits_d;

  assign cfg_ready_o = 1'b1;
  assign full        = mid_full;
  assign in_accept   = push && !full;

  always_comb begin
    limits_d = limits_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTempLow:  limits_d.low  = $signed(cfg_data_i);
        CfgTempHigh: limits_d.high = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.low  <= TempLowReset;
      limits_q.high <= TempHighReset;
    end else begin
      limits_q <= limits_d;
    end
  end

  sfcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .in_i        (in_data_i),
    .rec_valid_o (mid_push),
    .rec_o       (mid_in)
  );

  sfcd_fifo #(
    .Width ($bits(frame_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  sfcd_back u_back (
    .rec_valid_i (!mid_empty),
    .rec_i       (mid_out),
    .rec_pop_o   (mid_pop),
    .limits_i    (limits_q),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_data)
  );

  sfcd_fifo #(
    .Width ($bits(out_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

  // A finished frame must never arrive at a full frame queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mid_push |-> !mid_full)
    else $error("frame word produced while the frame queue is full");

  // A start word is always byte 0 and can never complete a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.frame_start) |-> !mid_push)
    else $error("start word completed a frame");

  // Words leave the frame queue only as results enter the output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> (!mid_empty && !res_full && res_push))
    else $error("frame word dropped between front and back ends");

endmodule

/* hdl/sfcd_fifo.sv */
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder queue
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module sfcd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/sfcd_front.sv */
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder front end
// Tracks the byte position, runs the CRC and assembles complete frames.
// ----------------------------------------------------------------------------
module sfcd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  sfcd_pkg::in_t  in_i,
  output logic           rec_valid_o,
  output sfcd_pkg::frame_t rec_o
);
  import sfcd_pkg::*;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d, crc_in, crc_next;
  logic [15:0] temp_word_q, temp_word_d;
  logic [7:0]  temp_chk_q, temp_chk_d;
  logic        temp_ok_q, temp_ok_d;
  logic [15:0] hum_word_q, hum_word_d;
  logic [7:0]  b;

  assign b = in_i.frame_byte;

  always_comb begin
    // A start word or a stray count begins a fresh frame.
    pos = (in_i.frame_start || (pos_q > FrameLast)) ? 3'd0 : pos_q;
    crc_in = (pos == 3'd0) ? CrcInit : crc_q;
    crc_next = crc8_feed(crc_in, b);

    pos_d       = pos_q;
    crc_d       = crc_q;
    temp_word_d = temp_word_q;
    temp_chk_d  = temp_chk_q;
    temp_ok_d   = temp_ok_q;
    hum_word_d  = hum_word_q;
    rec_valid_o = 1'b0;

    rec_o.temp_word  = temp_word_q;
    rec_o.temp_check = temp_chk_q;
    rec_o.hum_word   = hum_word_q;
    rec_o.hum_check  = b;
    rec_o.temp_ok    = temp_ok_q;
    rec_o.hum_ok     = (crc_in == b);

    if (accept_i) begin
      pos_d = pos + 3'd1;
      unique case (pos)
        3'd0: begin
          temp_word_d = {b, 8'h00};
          crc_d = crc_next;
        end
        3'd1: begin
          temp_word_d = {temp_word_q[15:8], b};
          crc_d = crc_next;
        end
        3'd2: begin
          temp_chk_d = b;
          temp_ok_d  = (crc_in == b);
          crc_d      = CrcInit;
        end
        3'd3: begin
          hum_word_d = {b, 8'h00};
          crc_d = crc_next;
        end
        3'd4: begin
          hum_word_d = {hum_word_q[15:8], b};
          crc_d = crc_next;
        end
        default: begin
          rec_valid_o = 1'b1;
          crc_d = CrcInit;
          pos_d = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CrcInit;
      temp_word_q <= '0;
      temp_chk_q  <= '0;
      temp_ok_q   <= 1'b0;
      hum_word_q  <= '0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      temp_chk_q  <= temp_chk_d;
      temp_ok_q   <= temp_ok_d;
      hum_word_q  <= hum_word_d;
    end
  end

endmodule

/* hdl/sfcd_back.sv */
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder back end
// Converts the temperature, checks limits and builds the result word.
// ----------------------------------------------------------------------------
module sfcd_back (
  input  logic              rec_valid_i,
  input  sfcd_pkg::frame_t  rec_i,
  output logic              rec_pop_o,
  input  sfcd_pkg::limits_t limits_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output sfcd_pkg::out_t    res_o
);
  import sfcd_pkg::*;

  logic signed [11:0] tenths;
  logic               out_of_range;

  assign tenths = to_tenths(rec_i.temp_word);
  assign out_of_range = (tenths < limits_i.low) || (tenths > limits_i.high);

  assign res_push_o = rec_valid_i && !res_full_i;
  assign rec_pop_o  = res_push_o;

  always_comb begin
    res_o.temp_reading       = rec_i.temp_word;
    res_o.temperature_check  = rec_i.temp_check;
    res_o.hum_reading        = rec_i.hum_word;
    res_o.humidity_check     = rec_i.hum_check;
    res_o.temperature_crc_ok = rec_i.temp_ok;
    res_o.humidity_crc_ok    = rec_i.hum_ok;
    res_o.temperature_tenths = tenths;
    if (!rec_i.temp_ok) begin
      res_o.status = STATUS_TEMP_CRC;
    end else if (!rec_i.hum_ok) begin
      res_o.status = STATUS_HUM_CRC;
    end else if (out_of_range) begin
      res_o.status = STATUS_RANGE;
    end else begin
      res_o.status = STATUS_OK;
    end
  end

endmodule

/* tb/tb_sensor_frame_crc_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder testbench
// Streams directed and random six-byte frames through the decoder with bursty input
// and a stalling reader. Every decoded word is predicted here or typed in by hand,
// and checked field by field. The temperature limits change between run phases.
// ----------------------------------------------------------------------------
module tb_sensor_frame_crc_decoder_core;
  import sfcd_pkg::*;

  localparam int ResetCycles = 7;
  localparam int NumPhases = 7;
  localparam int PhaseBytes = 120;
  localparam int SettleCycles = 8;
  localparam int WatchdogLimit = 1000;
  localparam int MaxReports = 40;
  localparam logic [CfgIndexWidth-1:0] CfgStrayFirst = CfgTempHigh + 1'b1;
  localparam logic [CfgIndexWidth-1:0] CfgStrayLast = '1;

  typedef struct {
    logic [7:0] b;
    logic       s;
    bit         pin;
    out_t       want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // A byte offered with word_pinned set carries its decoded word typed in by hand.
  logic word_pinned = 1'b0;
  out_t word_want = '0;

  // Frame decoder state as seen from outside.
  logic [2:0] fr_pos = '0;
  logic [7:0] fr_crc = CrcInit;
  logic [15:0] fr_temp = '0;
  logic [7:0] fr_temp_chk = '0;
  logic fr_temp_good = 1'b0;
  logic [15:0] fr_hum = '0;
  logic signed [11:0] lim_lo = TempLowReset;
  logic signed [11:0] lim_hi = TempHighReset;

  out_t decoded_q[$];
  script_row_t script[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int unsigned rx_cycle = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  bit mid_frame = 1'b0;

  sensor_frame_crc_decoder_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bit-serial CRC-8, data MSB first.
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = crc[7] ^ b[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  function automatic logic [7:0] crc_word(logic [15:0] w);
    return crc8_step(crc8_step(CrcInit, w[15:8]), w[7:0]);
  endfunction

  // Advances the frame state by one byte; returns 1 when a word is decoded.
  function automatic bit decode_byte(input in_t item, output out_t res);
    logic [7:0] b;
    int scaled;
    int tenths;
    bit hum_good;
    bit done;
    b = item.frame_byte;
    res = '0;
    done = 1'b0;
    if (item.frame_start || fr_pos > FrameLast) fr_pos = '0;
    if (fr_pos == '0) fr_crc = CrcInit;
    case (fr_pos)
      3'd0: begin
        fr_temp = {b, 8'h00};
        fr_crc = crc8_step(fr_crc, b);
      end
      3'd1: begin
        fr_temp[7:0] = b;
        fr_crc = crc8_step(fr_crc, b);
      end
      3'd2: begin
        fr_temp_chk = b;
        fr_temp_good = (fr_crc == b);
        fr_crc = CrcInit;
      end
      3'd3: begin
        fr_hum = {b, 8'h00};
        fr_crc = crc8_step(fr_crc, b);
      end
      3'd4: begin
        fr_hum[7:0] = b;
        fr_crc = crc8_step(fr_crc, b);
      end
      default: begin
        hum_good = (fr_crc == b);
        // Scale by 10/256 with rounding half away from zero.
        scaled = int'($signed(fr_temp)) * 10;
        tenths = (scaled >= 0) ? (scaled + 128) / 256 : -((128 - scaled) / 256);
        tenths += int'(TenthsOffset);
        res.temp_reading = fr_temp;
        res.temperature_check = fr_temp_chk;
        res.hum_reading = fr_hum;
        res.humidity_check = b;
        res.temperature_crc_ok = fr_temp_good;
        res.humidity_crc_ok = hum_good;
        res.temperature_tenths = 12'(tenths);
        if (!fr_temp_good) res.status = STATUS_TEMP_CRC;
        else if (!hum_good) res.status = STATUS_HUM_CRC;
        else if (tenths < int'(lim_lo) || tenths > int'(lim_hi)) res.status = STATUS_RANGE;
        else res.status = STATUS_OK;
        fr_crc = CrcInit;
        done = 1'b1;
      end
    endcase
    fr_pos = done ? 3'd0 : fr_pos + 3'd1;
    return done;
  endfunction

  task automatic report(input string field, input logic [31:0] exp_v,
                        input logic [31:0] got_v);
    if (mismatches < MaxReports) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, exp_v, got_v);
    end
    mismatches++;
  endtask

  // Reader stalls on a pattern chosen by bits 8:7 of a free-running cycle counter.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: pop <= 1'b1;
      2'd1: pop <= 1'($urandom_range(0, 1));
      2'd2: pop <= (rx_cycle[3:0] < 4'd3);
      default: pop <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin : watch
    out_t predicted;
    out_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          report("word with none pending", '0, out_data.temp_reading);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.temp_reading !== want.temp_reading)
            report("temp_reading", want.temp_reading, out_data.temp_reading);
          if (out_data.temperature_check !== want.temperature_check)
            report("temperature_check", want.temperature_check, out_data.temperature_check);
          if (out_data.hum_reading !== want.hum_reading)
            report("hum_reading", want.hum_reading, out_data.hum_reading);
          if (out_data.humidity_check !== want.humidity_check)
            report("humidity_check", want.humidity_check, out_data.humidity_check);
          if (out_data.temperature_crc_ok !== want.temperature_crc_ok)
            report("temperature_crc_ok", want.temperature_crc_ok, out_data.temperature_crc_ok);
          if (out_data.humidity_crc_ok !== want.humidity_crc_ok)
            report("humidity_crc_ok", want.humidity_crc_ok, out_data.humidity_crc_ok);
          if (out_data.temperature_tenths !== want.temperature_tenths)
            report("temperature_tenths", want.temperature_tenths, out_data.temperature_tenths);
          if (out_data.status !== want.status)
            report("status", want.status, out_data.status);
        end
      end
      if (push && !full) begin
        if (decode_byte(in_data, predicted)) begin
          decoded_q.push_back(word_pinned ? word_want : predicted);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgTempLow: lim_lo = cfg_data;
          CfgTempHigh: lim_hi = cfg_data;
          default: ;
        endcase
      end
    end
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_row(input logic [7:0] b, input logic s, input bit pin = 1'b0,
                         input out_t want = '0);
    script_row_t row;
    row.b = b;
    row.s = s;
    row.pin = pin;
    row.want = want;
    script.push_back(row);
  endtask

  // Offers one byte and returns at the edge that accepts it, with push still high.
  task automatic send_byte(input logic [7:0] b, input logic s, input bit pin,
                           input out_t want);
    in_t item;
    int gap;
    item.frame_byte = b;
    item.frame_start = s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_data <= item;
    word_pinned <= pin;
    word_want <= want;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_limits(input logic signed [11:0] lo, input logic signed [11:0] hi,
                            input bit stray);
    if (stray) begin
      write_reg(CfgIndexWidth'($urandom_range(CfgStrayFirst, CfgStrayLast)), 12'($urandom));
    end
    write_reg(CfgTempLow, lo);
    write_reg(CfgTempHigh, hi);
    cfg_valid <= 1'b0;
  endtask

  // Stops input and waits until every decoded word has been read out.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic stream_frames(input int count);
    int stop_at;
    int r;
    int len;
    int target;
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    logic [7:0] t_chk;
    logic [7:0] h_chk;
    logic first_start;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        // A third of the frames land near one of the limits.
        if ($urandom_range(0, 2) == 0) begin
          target = $urandom_range(0, 1) ? int'(lim_hi) : int'(lim_lo);
          target = ((target - int'(TenthsOffset)) * 256) / 10
                   + int'($urandom_range(0, 50)) - 25;
          if (target > 32767) target = 32767;
          if (target < -32768) target = -32768;
          t_raw = 16'(target);
        end else begin
          t_raw = 16'($urandom);
        end
        h_raw = 16'($urandom);
        t_chk = crc_word(t_raw);
        h_chk = crc_word(h_raw);
        if ($urandom_range(0, 7) == 0) t_chk ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 7) == 0) h_chk ^= 8'($urandom_range(1, 255));
        first_start = mid_frame || ($urandom_range(0, 1) == 1);
        send_byte(t_raw[15:8], first_start, 1'b0, '0);
        send_byte(t_raw[7:0], 1'b0, 1'b0, '0);
        send_byte(t_chk, 1'b0, 1'b0, '0);
        send_byte(h_raw[15:8], 1'b0, 1'b0, '0);
        send_byte(h_raw[7:0], 1'b0, 1'b0, '0);
        send_byte(h_chk, 1'b0, 1'b0, '0);
        mid_frame = 1'b0;
      end else begin
        // Cut-off frames start properly; noise has random start flags.
        len = (r < 86) ? $urandom_range(1, 5) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom), (r < 86 && i == 0) ? 1'b1 : 1'($urandom_range(0, 1)),
                    1'b0, '0);
        end
        mid_frame = 1'b1;
      end
    end
  endtask

  initial begin
    out_t ok_want;
    out_t bad_want;
    ok_want = '0;
    ok_want.temp_reading = 16'hBEEF;
    ok_want.temperature_check = 8'h92;
    ok_want.hum_reading = 16'hBEEF;
    ok_want.humidity_check = 8'h92;
    ok_want.temperature_crc_ok = 1'b1;
    ok_want.humidity_crc_ok = 1'b1;
    ok_want.temperature_tenths = -12'sd251;
    ok_want.status = STATUS_OK;
    bad_want = ok_want;
    bad_want.temperature_check = 8'h00;
    bad_want.humidity_check = 8'h00;
    bad_want.temperature_crc_ok = 1'b0;
    bad_want.humidity_crc_ok = 1'b0;
    bad_want.status = STATUS_TEMP_CRC;

    // Clean frame with both check bytes correct.
    add_row(8'hBE, 1'b1);
    add_row(8'hEF, 1'b0);
    add_row(8'h92, 1'b0);
    add_row(8'hBE, 1'b0);
    add_row(8'hEF, 1'b0);
    add_row(8'h92, 1'b0, 1'b1, ok_want);
    // One byte of a frame, then a restart drops it. Maximum raw temperature.
    add_row(8'h12, 1'b1);
    add_row(8'h7F, 1'b1);
    add_row(8'hFF, 1'b0);
    add_row(crc_word(16'h7FFF), 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(crc_word(16'hFFFF) ^ 8'h01, 1'b0);
    // No start flag: the count wraps by itself. Minimum raw temperature.
    add_row(8'h80, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(crc_word(16'h8000), 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(crc_word(16'h0000), 1'b0);
    // Both check bytes wrong: the temperature error is reported first.
    add_row(8'hBE, 1'b1);
    add_row(8'hEF, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hBE, 1'b0);
    add_row(8'hEF, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, bad_want);

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_byte(script[i].b, script[i].s, script[i].pin, script[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: set_limits(-12'sd880, 12'sd1680, 1'b1);
          2: set_limits(12'sd1680, -12'sd880, 1'b0);
          3: set_limits(12'sd0, 12'sd0, 1'b1);
          4: set_limits(-12'sd880, -12'sd880, 1'b0);
          5: set_limits(12'sd1680, 12'sd1680, 1'b0);
          default: set_limits(12'(int'($urandom_range(0, 2560)) - 880),
                              12'(int'($urandom_range(0, 2560)) - 880), 1'b1);
        endcase
      end
      stream_frames(PhaseBytes);
    end

    drain();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sfcd_pkg.sv
hdl/sfcd_fifo.sv
hdl/sfcd_front.sv
hdl/sfcd_back.sv
hdl/sensor_frame_crc_decoder_core.sv
tb/tb_sensor_frame_crc_decoder_core.sv
